### design/gyro_to_pointer_motion_top_assert.svh
// ----------------------------------------------------------------------------
// Gyro to pointer motion - assertion macros
// Concurrent check wrappers on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GYRO_TO_POINTER_MOTION_TOP_ASSERT_SVH
`define GYRO_TO_POINTER_MOTION_TOP_ASSERT_SVH

// same-cycle implication
`define GTPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gtpm_pkg.sv
// ----------------------------------------------------------------------------
// Gyro to pointer motion - package
// Widths, register indexes and controller states shared by the design.
// ----------------------------------------------------------------------------
package gtpm_pkg;

  localparam int RATE_W           = 16;
  localparam int MOVE_W           = 16;
  localparam int SAMPLE_BITS      = 16;
  localparam int FILTER_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS   = 8;
  localparam int SMOOTH_W         = SAMPLE_BITS + FILTER_FRAC_BITS;

  // calibration length, power of two: bias is an arithmetic shift of the sum
  localparam int CAL_SAMPLES = 256;
  localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES);
  localparam int CAL_SUM_W   = SAMPLE_BITS + CAL_SHIFT;
  localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);

  // shift-add unit
  localparam int ALPHA_W    = 16;
  localparam int DEAD_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int MUL_STEPS  = ALPHA_W;
  localparam int MCAND_W    = SMOOTH_W + 1;
  localparam int ACC_W      = MCAND_W + 1;
  localparam int MOT_TAIL   = FILTER_FRAC_BITS + GAIN_FRAC_BITS - MUL_STEPS;
  localparam int MOTQ_W     = SMOOTH_W - MOT_TAIL;
  localparam int PHASE_LAST = MUL_STEPS + 1;
  localparam int CNT_W      = $clog2(PHASE_LAST + 1);

  localparam int IN_TDATA_W  = 2 * RATE_W;
  localparam int OUT_TDATA_W = 2 * MOVE_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_ALPHA    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_HORIZONTAL = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_VERTICAL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MOTION_FLOOR    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MOTION_CEILING  = 3'd5;

  localparam logic [ALPHA_W-1:0]       ALPHA_RST = 16'd52429;
  localparam logic signed [GAIN_W-1:0] GAIN_RST  = 16'sd256;
  localparam logic signed [MOVE_W-1:0] FLOOR_RST = -16'sd127;
  localparam logic signed [MOVE_W-1:0] CEIL_RST  = 16'sd127;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FILT_X = 6'b000010,
    S_FILT_Y = 6'b000100,
    S_MOT_X  = 6'b001000,
    S_MOT_Y  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

### design/gyro_to_pointer_motion_top.sv
// ----------------------------------------------------------------------------
// Gyro to pointer motion - top level
// Rate samples: one item at a time, run through four phases of one shared
// bit-serial shift-add unit.
// Reset (rst_n low, synchronous) clears bias, sums, filters and config.
// ----------------------------------------------------------------------------
module gyro_to_pointer_motion_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gtpm_pkg::IN_TDATA_W-1:0]     in_tdata,   // rate_x, rate_y
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gtpm_pkg::OUT_TDATA_W-1:0]    out_tdata,  // move_x, move_y
  output logic                                out_tuser,  // calibrating
  input  logic                                cfg_we,
  input  logic [gtpm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [gtpm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gtpm_pkg::*;

  // config
  logic        [ALPHA_W-1:0] alpha_r;
  logic        [DEAD_W-1:0]  dead_band_r;
  logic signed [GAIN_W-1:0]  gain_h_r, gain_v_r;
  logic signed [MOVE_W-1:0]  floor_r, ceil_r;

  // state
  state_t                      state_r, state_nxt;
  logic        [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] bias_x_r, bias_x_nxt, bias_y_r, bias_y_nxt;
  logic signed [CAL_SUM_W-1:0] cal_sum_x_r, cal_sum_x_nxt, cal_sum_y_r, cal_sum_y_nxt;
  logic        [CAL_CNT_W-1:0] cal_cnt_r, cal_cnt_nxt;
  logic                        cal_active_r, cal_active_nxt;
  logic signed [SMOOTH_W-1:0]  smooth_x_r, smooth_x_nxt, smooth_y_r, smooth_y_nxt;
  logic signed [RATE_W-1:0]    samp_x_r, samp_x_nxt, samp_y_r, samp_y_nxt;

  // shift-add unit
  logic signed [MCAND_W-1:0]   mcand_r, mcand_nxt;
  logic        [MUL_STEPS-1:0] mplier_r, mplier_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [SMOOTH_W-1:0]  base_r, base_nxt;
  logic                        neg_r, neg_nxt;

  // result
  logic signed [MOVE_W-1:0]    res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                        res_cal_r, res_cal_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;
  logic                        out_user_r, out_user_nxt;

  // datapath helpers
  logic                        in_fire;
  logic signed [RATE_W-1:0]    in_rate_x, in_rate_y;
  logic signed [CAL_SUM_W-1:0] sum_x_upd, sum_y_upd;
  logic        [CAL_CNT_W-1:0] cal_cnt_inc;
  logic                        sel_x;
  logic signed [RATE_W-1:0]    f_raw;
  logic signed [SAMPLE_BITS-1:0] f_bias, f_d;
  logic signed [SAMPLE_BITS:0] f_diff;
  logic signed [SMOOTH_W-1:0]  f_old, f_t;
  logic signed [MCAND_W-1:0]   f_dd;
  logic signed [ACC_W-1:0]     f_sum;
  logic signed [SMOOTH_W-1:0]  m_s;
  logic signed [GAIN_W-1:0]    m_g;
  logic        [SMOOTH_W-1:0]  m_mag;
  logic                        m_dz;
  logic        [GAIN_W-1:0]    m_gmag;
  logic        [MOTQ_W-1:0]    m_q;
  logic signed [MOTQ_W:0]      m_val, m_lo, m_fin;
  logic signed [ACC_W:0]       step_add, step_sum;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_rate_x  = in_tdata[RATE_W-1:0];
  assign in_rate_y  = in_tdata[IN_TDATA_W-1:RATE_W];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sum_x_upd   = cal_sum_x_r + CAL_SUM_W'(in_rate_x);
    sum_y_upd   = cal_sum_y_r + CAL_SUM_W'(in_rate_y);
    cal_cnt_inc = cal_cnt_r + 1'b1;

    // filter operands: target and old - target
    sel_x  = (state_r == S_FILT_X);
    f_raw  = sel_x ? samp_x_r : samp_y_r;
    f_bias = sel_x ? bias_x_r : bias_y_r;
    f_old  = sel_x ? smooth_x_r : smooth_y_r;
    f_diff = (SAMPLE_BITS+1)'(f_raw) - (SAMPLE_BITS+1)'(f_bias);
    if (f_diff[SAMPLE_BITS] != f_diff[SAMPLE_BITS-1]) begin
      f_d = f_diff[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      f_d = f_diff[SAMPLE_BITS-1:0];
    end
    f_t   = {f_d, {FILTER_FRAC_BITS{1'b0}}};
    f_dd  = MCAND_W'(f_old) - MCAND_W'(f_t);
    f_sum = ACC_W'(base_r) + acc_r;

    // motion operands: sign-magnitude, deadzone
    m_s    = (state_r == S_MOT_X) ? smooth_y_r : smooth_x_r;
    m_g    = (state_r == S_MOT_X) ? gain_h_r : gain_v_r;
    m_mag  = m_s[SMOOTH_W-1] ? SMOOTH_W'(-m_s) : SMOOTH_W'(m_s);
    m_dz   = m_mag < SMOOTH_W'({dead_band_r, {FILTER_FRAC_BITS{1'b0}}});
    m_gmag = m_g[GAIN_W-1] ? GAIN_W'(-m_g) : GAIN_W'(m_g);

    // motion commit: truncate toward zero, then floor and ceiling
    m_q   = acc_r[SMOOTH_W-1:MOT_TAIL];
    m_val = neg_r ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});
    m_lo  = (m_val < (MOTQ_W+1)'(floor_r)) ? (MOTQ_W+1)'(floor_r) : m_val;
    m_fin = (m_lo > (MOTQ_W+1)'(ceil_r)) ? (MOTQ_W+1)'(ceil_r) : m_lo;

    // one multiplier bit per cycle, accumulator shifts right with floor
    step_add = mplier_r[0] ? (ACC_W+1)'(mcand_r) : '0;
    step_sum = (ACC_W+1)'(acc_r) + step_add;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    bias_x_nxt     = bias_x_r;
    bias_y_nxt     = bias_y_r;
    cal_sum_x_nxt  = cal_sum_x_r;
    cal_sum_y_nxt  = cal_sum_y_r;
    cal_cnt_nxt    = cal_cnt_r;
    cal_active_nxt = cal_active_r;
    smooth_x_nxt   = smooth_x_r;
    smooth_y_nxt   = smooth_y_r;
    samp_x_nxt     = samp_x_r;
    samp_y_nxt     = samp_y_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    neg_nxt        = neg_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_cal_nxt    = res_cal_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_x_nxt   = '0;
          res_y_nxt   = '0;
          res_cal_nxt = 1'b1;
          if (in_tuser) begin
            cal_active_nxt = 1'b1;
            cal_cnt_nxt    = '0;
            cal_sum_x_nxt  = '0;
            cal_sum_y_nxt  = '0;
            state_nxt      = S_DONE;
          end else if (cal_active_r) begin
            cal_sum_x_nxt = sum_x_upd;
            cal_sum_y_nxt = sum_y_upd;
            cal_cnt_nxt   = cal_cnt_inc;
            if (cal_cnt_inc == CAL_CNT_W'(CAL_SAMPLES)) begin
              bias_x_nxt     = sum_x_upd[CAL_SUM_W-1:CAL_SHIFT];
              bias_y_nxt     = sum_y_upd[CAL_SUM_W-1:CAL_SHIFT];
              smooth_x_nxt   = '0;
              smooth_y_nxt   = '0;
              cal_active_nxt = 1'b0;
              cal_cnt_nxt    = '0;
            end
            state_nxt = S_DONE;
          end else begin
            samp_x_nxt  = in_rate_x;
            samp_y_nxt  = in_rate_y;
            res_cal_nxt = 1'b0;
            cnt_nxt     = '0;
            state_nxt   = S_FILT_X;
          end
        end
      end
      S_FILT_X, S_FILT_Y: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          mcand_nxt  = f_dd;
          mplier_nxt = alpha_r;
          acc_nxt    = '0;
          base_nxt   = f_t;
        end else if (cnt_r <= CNT_W'(MUL_STEPS)) begin
          acc_nxt    = step_sum[ACC_W:1];
          mplier_nxt = mplier_r >> 1;
        end else begin
          cnt_nxt = '0;
          if (sel_x) begin
            smooth_x_nxt = f_sum[SMOOTH_W-1:0];
            state_nxt    = S_FILT_Y;
          end else begin
            smooth_y_nxt = f_sum[SMOOTH_W-1:0];
            state_nxt    = S_MOT_X;
          end
        end
      end
      S_MOT_X, S_MOT_Y: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          mcand_nxt  = m_dz ? '0 : $signed({1'b0, m_mag});
          mplier_nxt = m_gmag;
          acc_nxt    = '0;
          // move_y uses the negated x rate
          neg_nxt    = ((state_r == S_MOT_X) ? m_s[SMOOTH_W-1] : !m_s[SMOOTH_W-1])
                       ^ m_g[GAIN_W-1];
        end else if (cnt_r <= CNT_W'(MUL_STEPS)) begin
          acc_nxt    = step_sum[ACC_W:1];
          mplier_nxt = mplier_r >> 1;
        end else begin
          cnt_nxt = '0;
          if (state_r == S_MOT_X) begin
            res_x_nxt = m_fin[MOVE_W-1:0];
            state_nxt = S_MOT_Y;
          end else begin
            res_y_nxt = m_fin[MOVE_W-1:0];
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_y_r, res_x_r};
          out_user_nxt  = res_cal_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      bias_x_r     <= '0;
      bias_y_r     <= '0;
      cal_sum_x_r  <= '0;
      cal_sum_y_r  <= '0;
      cal_cnt_r    <= '0;
      cal_active_r <= 1'b0;
      smooth_x_r   <= '0;
      smooth_y_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      bias_x_r     <= bias_x_nxt;
      bias_y_r     <= bias_y_nxt;
      cal_sum_x_r  <= cal_sum_x_nxt;
      cal_sum_y_r  <= cal_sum_y_nxt;
      cal_cnt_r    <= cal_cnt_nxt;
      cal_active_r <= cal_active_nxt;
      smooth_x_r   <= smooth_x_nxt;
      smooth_y_r   <= smooth_y_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_x_r   <= samp_x_nxt;
    samp_y_r   <= samp_y_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_cal_r  <= res_cal_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RST;
      dead_band_r <= '0;
      gain_h_r    <= GAIN_RST;
      gain_v_r    <= GAIN_RST;
      floor_r     <= FLOOR_RST;
      ceil_r      <= CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FILTER_ALPHA:    alpha_r     <= cfg_wdata[ALPHA_W-1:0];
        REG_DEAD_BAND:       dead_band_r <= cfg_wdata[DEAD_W-1:0];
        REG_GAIN_HORIZONTAL: gain_h_r    <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_VERTICAL:   gain_v_r    <= cfg_wdata[GAIN_W-1:0];
        REG_MOTION_FLOOR:    floor_r     <= cfg_wdata[MOVE_W-1:0];
        REG_MOTION_CEILING:  ceil_r      <= cfg_wdata[MOVE_W-1:0];
        default: ;
      endcase
    end
  end

`include "gyro_to_pointer_motion_top_assert.svh"

  `GTPM_ASSERT_IMP(a_cal_zero_motion, out_tvalid && out_tuser, out_tdata == '0, "nonzero motion while calibrating")
  `GTPM_ASSERT_IMP(a_cal_cnt_idle, !cal_active_r, cal_cnt_r == '0, "calibration count left over")
  `GTPM_ASSERT_IMP(a_step_cnt_range, state_r != S_IDLE, cnt_r <= CNT_W'(PHASE_LAST), "phase counter overrun")
  `GTPM_ASSERT_NXT(a_sample_starts_filter, in_fire && !in_tuser && !cal_active_r, state_r == S_FILT_X, "sample did not start filter")

endmodule
